@@ sv/cr_pkg.sv @@
// Shared types and constants for the circle rasterizer.
package cr_pkg;

  localparam int OUT_W       = 12;
  localparam int RAD_W       = 9;
  localparam int DEC_W       = 13;
  localparam int CALC_W      = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [DEC_W-1:0]  DEC_INIT   = DEC_W'(3);
  localparam logic signed [CALC_W-1:0] DEC_STEP_Y = CALC_W'(10);
  localparam logic signed [CALC_W-1:0] DEC_STEP_X = CALC_W'(6);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
    logic [RAD_W-1:0] radius;
  } job_t;

endpackage

@@ sv/circle_rasterizer.sv @@
// Midpoint circle rasterizer top level: one octant step per request.
//
// Usage: each request on the req channel (req_valid/req_stall) carries cmd,
// center_x, center_y and radius. cmd = 0 starts a circle at the given centre
// and returns its first step; cmd = 1 returns the next step of the running
// circle. Every request yields exactly one result on the step channel
// (step_valid/step_stall): valid_res, the eight mirrored coordinates and last.
// last marks the final octant step, after which the generator is idle; an
// advance while idle returns valid_res = 0 with all other fields zero. A start
// while a circle runs abandons it.
// A request passes the intake register, the two-entry job queue and the result
// register on its way to a result. Throughput: one request per cycle while the
// receiver does not stall.
// Reset: clears the channel valid flags and the queue; the generator comes up idle.
// When the receiver stalls, the result holds, the queue fills and then
// req_stall rises; no request is lost or repeated.
module circle_rasterizer import cr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic                    cmd,
  input  logic [COORD_BITS-1:0]   center_x,
  input  logic [COORD_BITS-1:0]   center_y,
  input  logic [RAD_W-1:0]        radius,
  output logic                    step_valid,
  input  logic                    step_stall,
  output logic                    valid_res,
  output logic signed [OUT_W-1:0] cx_plus_x,
  output logic signed [OUT_W-1:0] cx_minus_x,
  output logic signed [OUT_W-1:0] cx_plus_y,
  output logic signed [OUT_W-1:0] cx_minus_y,
  output logic signed [OUT_W-1:0] cy_plus_y,
  output logic signed [OUT_W-1:0] cy_minus_y,
  output logic signed [OUT_W-1:0] cy_plus_x,
  output logic signed [OUT_W-1:0] cy_minus_x,
  output logic                    last
);

  logic front_valid;
  logic front_stall;
  job_t front_job;
  logic back_valid;
  logic back_stall;
  job_t back_job;

  cr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .job_valid (front_valid),
    .job_stall (front_stall),
    .job       (front_job)
  );

  cr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .in_job    (front_job),
    .out_valid (back_valid),
    .out_stall (back_stall),
    .out_job   (back_job)
  );

  cr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (back_valid),
    .job_stall  (back_stall),
    .job        (back_job),
    .step_valid (step_valid),
    .step_stall (step_stall),
    .valid_res  (valid_res),
    .cx_plus_x  (cx_plus_x),
    .cx_minus_x (cx_minus_x),
    .cx_plus_y  (cx_plus_y),
    .cx_minus_y (cx_minus_y),
    .cy_plus_y  (cy_plus_y),
    .cy_minus_y (cy_minus_y),
    .cy_plus_x  (cy_plus_x),
    .cy_minus_x (cy_minus_x),
    .last       (last)
  );

endmodule

@@ sv/cr_front.sv @@
// Request intake: classifies the command and registers it as a job.
module cr_front import cr_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  cmd,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [RAD_W-1:0]      radius,
  output logic                  job_valid,
  input  logic                  job_stall,
  output job_t                  job
);

  localparam int EXT_W = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;

  logic [EXT_W-1:0] cx_ext;
  logic [EXT_W-1:0] cy_ext;
  job_t             job_next;

  assign req_stall = job_valid & job_stall;
  assign cx_ext    = EXT_W'(center_x);
  assign cy_ext    = EXT_W'(center_y);

  always_comb begin
    job_next.op     = cmd ? OP_ADVANCE : OP_START;
    job_next.cx     = cx_ext[OUT_W-1:0];
    job_next.cy     = cy_ext[OUT_W-1:0];
    job_next.radius = radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!req_stall) begin
      job_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      job <= job_next;
    end
  end

endmodule

@@ sv/cr_queue.sv @@
// Short job queue between intake and step generator.
module cr_queue import cr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_stall,
  output job_t out_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_stall  = (count == CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid & ~in_stall;
  assign pop       = out_valid & ~out_stall;
  assign out_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

endmodule

@@ sv/cr_back.sv @@
// Step generator: midpoint state, mirrored coordinates and result register.
module cr_back import cr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  output logic                    job_stall,
  input  job_t                    job,
  output logic                    step_valid,
  input  logic                    step_stall,
  output logic                    valid_res,
  output logic signed [OUT_W-1:0] cx_plus_x,
  output logic signed [OUT_W-1:0] cx_minus_x,
  output logic signed [OUT_W-1:0] cx_plus_y,
  output logic signed [OUT_W-1:0] cx_minus_y,
  output logic signed [OUT_W-1:0] cy_plus_y,
  output logic signed [OUT_W-1:0] cy_minus_y,
  output logic signed [OUT_W-1:0] cy_plus_x,
  output logic signed [OUT_W-1:0] cy_minus_x,
  output logic                    last
);

  logic [RAD_W-1:0]         offset_x;
  logic [RAD_W-1:0]         offset_y;
  logic signed [DEC_W-1:0]  decision;
  logic [OUT_W-1:0]         centre_x_reg;
  logic [OUT_W-1:0]         centre_y_reg;
  logic                     active;

  logic                     pop;
  logic                     start;
  logic                     emit;
  logic [RAD_W-1:0]         x_cur;
  logic [RAD_W-1:0]         y_cur;
  logic signed [DEC_W-1:0]  d_cur;
  logic [OUT_W-1:0]         xc;
  logic [OUT_W-1:0]         yc;
  logic [OUT_W-1:0]         x_w;
  logic [OUT_W-1:0]         y_w;
  logic signed [CALC_W-1:0] xe;
  logic signed [CALC_W-1:0] ye;
  logic signed [CALC_W-1:0] de;
  logic signed [CALC_W-1:0] d_next;
  logic signed [CALC_W-1:0] nx;
  logic signed [CALC_W-1:0] ny;
  logic                     is_last;

  assign job_stall = step_valid & step_stall;
  assign pop       = job_valid & ~job_stall;
  assign start     = (job.op == OP_START);
  assign emit      = start | active;

  always_comb begin
    x_cur = start ? '0 : offset_x;
    y_cur = start ? job.radius : offset_y;
    d_cur = start ? DEC_INIT - $signed({3'b000, job.radius, 1'b0}) : decision;
    xc    = start ? job.cx : centre_x_reg;
    yc    = start ? job.cy : centre_y_reg;
    x_w   = OUT_W'(x_cur);
    y_w   = OUT_W'(y_cur);
    xe    = $signed(CALC_W'(x_cur));
    ye    = $signed(CALC_W'(y_cur));
    de    = CALC_W'(d_cur);
    nx    = xe + CALC_W'(1);
    if (d_cur > 0) begin
      d_next = de + ((xe - ye) <<< 2) + DEC_STEP_Y;
      ny     = ye - CALC_W'(1);
    end else begin
      d_next = de + (xe <<< 2) + DEC_STEP_X;
      ny     = ye;
    end
    is_last = (nx > ny);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop && emit) begin
      active <= ~is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit && !is_last) begin
      offset_x     <= nx[RAD_W-1:0];
      offset_y     <= ny[RAD_W-1:0];
      decision     <= d_next[DEC_W-1:0];
      centre_x_reg <= xc;
      centre_y_reg <= yc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (!job_stall) begin
      step_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      valid_res  <= emit;
      last       <= emit & is_last;
      cx_plus_x  <= emit ? xc + x_w : '0;
      cx_minus_x <= emit ? xc - x_w : '0;
      cx_plus_y  <= emit ? xc + y_w : '0;
      cx_minus_y <= emit ? xc - y_w : '0;
      cy_plus_y  <= emit ? yc + y_w : '0;
      cy_minus_y <= emit ? yc - y_w : '0;
      cy_plus_x  <= emit ? yc + x_w : '0;
      cy_minus_x <= emit ? yc - x_w : '0;
    end
  end

  a_last_ends_circle: assert property (@(posedge clk) disable iff (rst)
    step_valid && last |-> !active)
    else $error("circle still active after final step");

  a_idle_result_clear: assert property (@(posedge clk) disable iff (rst)
    step_valid && !valid_res |-> !last && cx_plus_x == '0 && cy_minus_x == '0)
    else $error("idle advance produced a nonzero result");

  a_octant_order: assert property (@(posedge clk) disable iff (rst)
    active |-> offset_x <= offset_y)
    else $error("offset x passed offset y while active");

  a_start_takes_effect: assert property (@(posedge clk) disable iff (rst)
    pop && start |=> active || (step_valid && last))
    else $error("start request did not begin a circle");

endmodule
